>>> sv/assert_macros.svh
// Assertion macros shared by the binary GCD RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a property never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) not (prop)) \
      else $error(msg);

`endif

>>> sv/bgcd_pkg.sv
// Types and constants of the binary GCD pipeline.
`timescale 1ns / 1ps

package bgcd_pkg;

   // datapath width of the operands
   localparam int WIDTH  = 32;
   // width of the ports
   localparam int PORT_W = 32;
   // one reduction stage per bit of the summed operand lengths
   localparam int STAGES = 2 * WIDTH;
   // count of common factors of two, at most WIDTH-1
   localparam int TWOS_W = $clog2(WIDTH);

   // low bits of the larger and the smaller value
   typedef enum logic [1:0] {
      BOTH_EVEN = 2'b00,
      MIN_ODD   = 2'b01,
      MAX_ODD   = 2'b10,
      BOTH_ODD  = 2'b11
   } parity_type;

   typedef struct packed {
      logic              valid;
      logic [WIDTH-1:0]  x;
      logic [WIDTH-1:0]  y;
      logic [TWOS_W-1:0] twos;
   } stage_type;

endpackage

>>> sv/binary_gcd.sv
// Top level of the pipelined binary GCD block.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// binary_gcd returns the greatest common divisor of two unsigned 32-bit
// words by the binary (Stein) method; gcd(x,0) is x and gcd(0,0) is 0.
// The work runs through a pipeline of 2*WIDTH (64) reduction stages plus one
// output register, and a new operand pair can enter on every cycle while the
// pipeline is not stalled. Each stage orders
// the pair, then halves both (counting a common two), halves the even one,
// or takes the halved difference of two odd values; every step shortens the
// pair by at least one bit, so the stage count bounds the work. The output
// register shifts the remaining value left by the common twos. A stall on
// the result side freezes the whole pipeline, and req_stall rises with it.

module binary_gcd
   import bgcd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [PORT_W-1:0] req_operand_a,
   input  logic [PORT_W-1:0] req_operand_b,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PORT_W-1:0] rsp_divisor
);

   stage_type         pipe [0:STAGES];

   logic              advance;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0] divisor_ff, divisor_in;

   // advance everything unless a result word waits and is stalled
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // operands enter at the datapath width
   assign pipe[0].valid = req_valid;
   assign pipe[0].x     = WIDTH'(req_operand_a);
   assign pipe[0].y     = WIDTH'(req_operand_b);
   assign pipe[0].twos  = '0;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      bgcd_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (pipe[i]),
         .stage_out (pipe[i+1])
      );
   end

   // one value of the final pair is zero: merge them and restore the twos
   assign rsp_valid_in = pipe[STAGES].valid;
   assign divisor_in   = PORT_W'((pipe[STAGES].x | pipe[STAGES].y) << pipe[STAGES].twos);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         divisor_ff <= divisor_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_divisor = divisor_ff;

   `ASSERT_ALWAYS(a_reduced_at_end,
      pipe[STAGES].valid |-> (pipe[STAGES].x == '0 || pipe[STAGES].y == '0),
      "pair not fully reduced at pipeline end")
   `ASSERT_NEVER(a_drain_empty,
      (rsp_valid && !rsp_stall && !pipe[STAGES].valid) ##1 rsp_valid,
      "result word repeated after being taken")

endmodule

>>> sv/bgcd_stage.sv
// One registered reduction step of the binary GCD pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bgcd_stage
   import bgcd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  stage_type stage_in,
   output stage_type stage_out
);

   logic              valid_ff, valid_in;
   logic [WIDTH-1:0]  x_ff, x_in;
   logic [WIDTH-1:0]  y_ff, y_in;
   logic [TWOS_W-1:0] twos_ff, twos_in;

   logic [WIDTH-1:0]  max_val;
   logic [WIDTH-1:0]  min_val;

   always_comb begin
      if (stage_in.y > stage_in.x) begin
         max_val = stage_in.y;
         min_val = stage_in.x;
      end else begin
         max_val = stage_in.x;
         min_val = stage_in.y;
      end

      valid_in = stage_in.valid;
      x_in     = max_val;
      y_in     = min_val;
      twos_in  = stage_in.twos;

      // a zero smaller value means done: hold the pair
      if (min_val != '0) begin
         case (parity_type'({max_val[0], min_val[0]}))
            BOTH_EVEN: begin
               x_in    = max_val >> 1;
               y_in    = min_val >> 1;
               twos_in = TWOS_W'(stage_in.twos + 1'b1);
            end
            MIN_ODD: begin
               x_in = max_val >> 1;
            end
            MAX_ODD: begin
               y_in = min_val >> 1;
            end
            BOTH_ODD: begin
               // difference of two odd values is even: halve it at once
               x_in = (max_val - min_val) >> 1;
            end
            default: begin
               x_in = max_val;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         twos_ff <= twos_in;
      end
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.x     = x_ff;
   assign stage_out.y     = y_ff;
   assign stage_out.twos  = twos_ff;

   `ASSERT_ALWAYS(a_nonzero_kept,
      (advance && stage_in.valid && ((stage_in.x | stage_in.y) != '0)) |=> ((x_ff | y_ff) != '0),
      "stage lost a nonzero pair")
   `ASSERT_ALWAYS(a_hold_on_stall, !advance |=> (valid_ff == $past(valid_ff)),
      "stage valid changed while stalled")

endmodule

>>> tb/binary_gcd_tb.sv
// Self-checking testbench of the binary GCD block.
`timescale 1ns / 1ps

module binary_gcd_tb
   import bgcd_pkg::*;
();

   // Depth of the pipeline: the reduction stages plus the output register.
   localparam int PIPE_LATENCY = 2 * WIDTH + 1;
   // Longest quiet stretch of a correct run is the long sink hold-off; take it
   // several times over.
   localparam int HOLD_LEN     = 300;
   localparam int QUIET_LIMIT  = 5000;
   localparam int N_DIRECTED   = 20;

   typedef enum int {
      PH_STEADY,
      PH_SRC_IDLE,
      PH_SINK_STALL,
      PH_BOTH,
      PH_HOLD
   } phase_type;

   // One directed word: operands, and the divisor where it is plain to see.
   typedef struct packed {
      logic [PORT_W-1:0] a;
      logic [PORT_W-1:0] b;
      logic              known;
      logic [PORT_W-1:0] divisor;
   } gcd_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [PORT_W-1:0] req_operand_a = '0;
   logic [PORT_W-1:0] req_operand_b = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [PORT_W-1:0] rsp_divisor;

   phase_type         phase = PH_STEADY;
   int                hold_count = 0;
   int                quiet_cycles = 0;
   int                errors = 0;
   logic [PORT_W-1:0] divisor_q [$];

   // Extremes, zero operands, equal and coprime pairs, and a Fibonacci pair
   // that drives the longest run of subtractions.
   gcd_row_type directed_rows [0:N_DIRECTED-1] = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{32'h0000_0000, 32'hffff_ffff, 1'b1, 32'hffff_ffff},
      '{32'hffff_ffff, 32'h0000_0000, 1'b1, 32'hffff_ffff},
      '{32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0001},
      '{32'h8000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000},
      '{32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_ffff},
      '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000},
      '{32'h0000_0001, 32'hffff_ffff, 1'b1, 32'h0000_0001},
      '{32'hffff_ffff, 32'h0000_0001, 1'b1, 32'h0000_0001},
      '{32'h8000_0000, 32'h0000_0001, 1'b1, 32'h0000_0001},
      '{32'h8000_0000, 32'h4000_0000, 1'b1, 32'h4000_0000},
      '{32'hffff_ffff, 32'hffff_fffe, 1'b1, 32'h0000_0001},
      '{32'h0000_0007, 32'h0000_0007, 1'b1, 32'h0000_0007},
      '{32'h0000_000c, 32'h0000_0012, 1'b0, 32'h0},
      '{32'h0000_0030, 32'h0000_00b4, 1'b0, 32'h0},
      '{32'haaaa_aaaa, 32'h5555_5555, 1'b0, 32'h0},
      '{32'hdead_beef, 32'h0bad_f00d, 1'b0, 32'h0},
      '{32'hffff_fffe, 32'h7fff_fffe, 1'b0, 32'h0},
      '{32'h6d73_e55f, 32'h43a5_3f82, 1'b0, 32'h0},
      '{32'hc000_0000, 32'h8000_0000, 1'b0, 32'h0}
   };

   binary_gcd dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_divisor   (rsp_divisor)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stein's method: order the pair, halve the even ones, subtract odd from
   // odd, and scale back by the common twos once the smaller value is zero.
   function automatic logic [PORT_W-1:0] stein_divisor(input logic [PORT_W-1:0] a,
                                                       input logic [PORT_W-1:0] b);
      logic [WIDTH-1:0] hi;
      logic [WIDTH-1:0] lo;
      logic [WIDTH-1:0] swap;
      int               twos;
      hi = a;
      lo = b;
      twos = 0;
      for (int step = 0; step < 4 * WIDTH; step++) begin
         if (lo > hi) begin
            swap = hi;
            hi = lo;
            lo = swap;
         end
         if (lo == '0)
            break;
         if (!hi[0] && !lo[0]) begin
            hi = hi >> 1;
            lo = lo >> 1;
            twos++;
         end else if (!hi[0]) begin
            hi = hi >> 1;
         end else if (!lo[0]) begin
            lo = lo >> 1;
         end else begin
            hi = hi - lo;
         end
      end
      return PORT_W'(hi << twos);
   endfunction

   function automatic int src_idle_pct(input phase_type ph);
      case (ph)
         PH_SRC_IDLE: return 61;
         PH_BOTH:     return 20;
         default:     return 0;
      endcase
   endfunction

   function automatic int sink_stall_pct(input phase_type ph);
      case (ph)
         PH_SINK_STALL: return 61;
         PH_BOTH:       return 20;
         default:       return 0;
      endcase
   endfunction

   // Drop valid for a random gap, as the current phase asks.
   task automatic src_gap();
      if ($urandom_range(99) < src_idle_pct(phase)) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < src_idle_pct(phase))
            @(posedge clock);
      end
   endtask

   // Offer one word and hold it until the block takes it; valid stays high so
   // that a following word can go out back to back.
   task automatic send_word(input logic [PORT_W-1:0] a, input logic [PORT_W-1:0] b,
                            input logic known, input logic [PORT_W-1:0] divisor);
      logic [PORT_W-1:0] want;
      want = known ? divisor : stein_divisor(a, b);
      src_gap();
      req_valid     <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      divisor_q.push_back(want);
   endtask

   // Random operand pair; most pairs share factors so that the common-two
   // and subtraction paths see real work.
   task automatic send_random();
      logic [PORT_W-1:0] a;
      logic [PORT_W-1:0] b;
      logic [PORT_W-1:0] g;
      case ($urandom_range(7))
         0, 1: begin
            a = $urandom;
            b = $urandom;
         end
         2, 3: begin
            g = $urandom >> $urandom_range(31);
            a = (g * $urandom_range(1, 1000)) << $urandom_range(6);
            b = (g * $urandom_range(1, 1000)) << $urandom_range(6);
         end
         4: begin
            a = $urandom;
            b = '0;
            if ($urandom_range(1)) begin
               b = a;
               a = '0;
            end
         end
         5: begin
            a = $urandom >> $urandom_range(31);
            b = a;
         end
         6: begin
            a = PORT_W'(1) << $urandom_range(31);
            b = $urandom << $urandom_range(31);
         end
         default: begin
            a = $urandom_range(255);
            b = $urandom_range(255);
         end
      endcase
      send_word(a, b, 1'b0, '0);
   endtask

   task automatic run_phase(input phase_type ph, input int count);
      phase = ph;
      repeat (count)
         send_random();
   endtask

   // Sink: random stalls per phase; in the hold phase, hold off for a long
   // stretch first so the pipeline backs up into the request side.
   always @(posedge clock) begin
      if (phase == PH_HOLD && hold_count < HOLD_LEN) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < sink_stall_pct(phase));
         if (phase != PH_HOLD)
            hold_count <= 0;
      end
   end

   // Compare each delivered word with the oldest expected divisor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (divisor_q.size() == 0) begin
            $display("%0t: unexpected word, divisor %h", $time, rsp_divisor);
            errors++;
         end else begin
            if (rsp_divisor !== divisor_q[0]) begin
               $display("%0t: divisor mismatch, expected %h, actual %h",
                        $time, divisor_q[0], rsp_divisor);
               errors++;
            end
            void'(divisor_q.pop_front());
         end
      end
   end

   // Count cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: timeout, %0d divisors still expected", $time, divisor_q.size());
      $display("binary_gcd regression: fail");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_word(directed_rows[i].a, directed_rows[i].b,
                   directed_rows[i].known, directed_rows[i].divisor);

      run_phase(PH_STEADY, 250);
      run_phase(PH_SRC_IDLE, 250);
      run_phase(PH_SINK_STALL, 250);
      run_phase(PH_BOTH, 250);
      run_phase(PH_HOLD, 150);

      // Pause the source until the pipeline has drained completely.
      phase = PH_STEADY;
      req_valid <= 1'b0;
      while (divisor_q.size() != 0)
         @(posedge clock);

      run_phase(PH_BOTH, 150);

      // Release the request side and let the last words flush out.
      req_valid <= 1'b0;
      phase = PH_STEADY;
      while (divisor_q.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 35) @(posedge clock);

      if (errors == 0)
         $display("binary_gcd regression: pass");
      else
         $display("binary_gcd regression: fail");
      $finish;
   end

endmodule
